/* rtl/core/nrcc_pkg.sv */
// ----------------------------------------------------------------------------
// nrcc_pkg
// Shared types, mode codes and the crc fold for the checksum checker.
// ----------------------------------------------------------------------------
package nrcc_pkg;

  // check_mode codes
  localparam logic [1:0] MODE_BYTE_SUM = 2'd0;
  localparam logic [1:0] MODE_WORD_SUM = 2'd1;
  localparam logic [1:0] MODE_NEG_SUM  = 2'd2;
  localparam logic [1:0] MODE_CRC      = 2'd3;

  localparam int          CRC_SHIFT_STEPS_DEF = 7;
  localparam int          CRC_STEPS_MAX       = 8;
  localparam logic [15:0] CRC_POLY            = 16'hA001;
  localparam logic [15:0] CRC_TOP_BIT         = 16'h8000;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] WIDTH_ONE_BYTE  = 2'd1;
  localparam logic [1:0] WIDTH_TWO_BYTES = 2'd2;

  // one classified item
  typedef struct packed {
    logic [1:0]  mode;
    logic        is_crc;
    logic        last;
    logic [7:0]  data;
    logic [15:0] stored;
  } entry_t;

  // XOR the byte in, then take the shift steps
  function automatic logic [15:0] crc_fold(input logic [15:0] acc,
                                           input logic [7:0]  b,
                                           input int          steps);
    logic [15:0] v;
    logic        out_bit;
    v = acc ^ {8'h00, b};
    for (int k = 0; k < CRC_STEPS_MAX; k++) begin
      if (k < steps) begin
        out_bit = v[0];
        v = v >> 1;
        if (out_bit) begin
          v = (v | CRC_TOP_BIT) ^ CRC_POLY;
        end
      end
    end
    return v;
  endfunction

endpackage

/* rtl/core/nrcc_front.sv */
// ----------------------------------------------------------------------------
// nrcc_front
// Input register stage: takes items, tags them with the current mode.
// ----------------------------------------------------------------------------
module nrcc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  input  logic [15:0]         in_stored,
  input  logic [1:0]          check_mode,
  output logic                push,
  input  logic                queue_ready,
  output nrcc_pkg::entry_t    entry
);

  logic held;

  assign push     = held && queue_ready;
  assign in_ready = !held || queue_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      entry.mode   <= check_mode;
      entry.is_crc <= (check_mode == nrcc_pkg::MODE_CRC);
      entry.last   <= in_last;
      entry.data   <= in_data;
      entry.stored <= in_stored;
    end
  end

endmodule

/* rtl/core/nrcc_queue.sv */
// ----------------------------------------------------------------------------
// nrcc_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module nrcc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             queue_ready,
  input  nrcc_pkg::entry_t wr_entry,
  output logic             head_valid,
  input  logic             pop,
  output nrcc_pkg::entry_t head
);

  nrcc_pkg::entry_t                 slots [nrcc_pkg::QUEUE_DEPTH];
  logic [nrcc_pkg::QUEUE_AW-1:0]    wptr;
  logic [nrcc_pkg::QUEUE_AW-1:0]    rptr;
  logic [nrcc_pkg::QUEUE_AW:0]      count;

  assign queue_ready = (count != (nrcc_pkg::QUEUE_AW+1)'(nrcc_pkg::QUEUE_DEPTH));
  assign head_valid  = (count != '0);
  assign head        = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_entry;
    end
  end

endmodule

/* rtl/core/nrcc_back.sv */
// ----------------------------------------------------------------------------
// nrcc_back
// Folds each byte into the running value; registers the result on last.
// ----------------------------------------------------------------------------
module nrcc_back #(
  parameter int CRC_SHIFT_STEPS = nrcc_pkg::CRC_SHIFT_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  nrcc_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      out_value,
  output logic [1:0]       out_bytes,
  output logic             out_match
);

  logic [15:0] running_value;
  logic [15:0] running_value_next;
  logic [15:0] value_next;
  logic [1:0]  bytes_next;
  logic        match_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;
  // non-last bytes never need the output register
  assign pop      = head_valid && (!head.last || out_free);

  always_comb begin
    if (head.is_crc) begin
      running_value_next = nrcc_pkg::crc_fold(running_value, head.data, CRC_SHIFT_STEPS);
    end else begin
      running_value_next = running_value + {8'h00, head.data};
    end
    case (head.mode)
      nrcc_pkg::MODE_BYTE_SUM: begin
        value_next = {8'h00, running_value_next[7:0]};
        bytes_next = nrcc_pkg::WIDTH_ONE_BYTE;
        match_next = (head.stored[7:0] == running_value_next[7:0]);
      end
      nrcc_pkg::MODE_NEG_SUM: begin
        value_next = (~running_value_next) + 16'd1;
        bytes_next = nrcc_pkg::WIDTH_TWO_BYTES;
        match_next = (head.stored == value_next);
      end
      default: begin
        value_next = running_value_next;
        bytes_next = nrcc_pkg::WIDTH_TWO_BYTES;
        match_next = (head.stored == value_next);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_value <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        running_value <= head.last ? 16'd0 : running_value_next;
      end
      if (pop && head.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_value <= value_next;
      out_bytes <= bytes_next;
      out_match <= match_next;
    end
  end

endmodule

/* rtl/core/nvram_range_checksum_checker.sv */
// ----------------------------------------------------------------------------
// nvram_range_checksum_checker
// Byte sum, word sum, negated word sum or crc fold over a memory range.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one byte of the range per item, ascending address order;
//    tlast marks the final byte, whose item also carries the stored checksum.
//  - m_axis gives one result per range: checksum, width in bytes, match flag.
//  - cfg_* writes check_mode; always ready. Write only while the block is idle.
// Path: an accepted last byte loads the front register, is then written into
//  the queue, and loads the back output register when it pops, and from that
//  register its result shows on m_axis.
// Throughput: one byte per cycle while the queue has room; the byte fold (add or
//  the unrolled crc shift steps) is combinational in the back stage.
// Stall: when m_axis stalls, non-last bytes still drain and fold; a last byte
//  waits at the queue head until the output register frees. Once the 4-entry
//  queue and the front register fill, s_axis_tready drops.
// Reset: rst (synchronous) clears check_mode to byte sum, the running value,
//  the queue and all valid flags.
// ----------------------------------------------------------------------------
module nvram_range_checksum_checker #(
  parameter int CRC_SHIFT_STEPS = nrcc_pkg::CRC_SHIFT_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] stored_checksum
  input  logic        s_axis_tlast,   // last_byte
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] checksum_value, [17:16] checksum_bytes,
                                      // [18] matches_stored, [23:19] zero
  // check_mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  logic [1:0]       check_mode;
  logic             push;
  logic             queue_ready;
  logic             head_valid;
  logic             pop;
  nrcc_pkg::entry_t front_entry;
  nrcc_pkg::entry_t head;
  logic [15:0]      out_value;
  logic [1:0]       out_bytes;
  logic             out_match;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode <= nrcc_pkg::MODE_BYTE_SUM;
    end else if (cfg_valid) begin
      check_mode <= cfg_data;
    end
  end

  // front: register and tag with mode
  nrcc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_data     (s_axis_tdata[7:0]),
    .in_last     (s_axis_tlast),
    .in_stored   (s_axis_tdata[23:8]),
    .check_mode  (check_mode),
    .push        (push),
    .queue_ready (queue_ready),
    .entry       (front_entry)
  );

  // decoupling queue
  nrcc_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .queue_ready (queue_ready),
    .wr_entry    (front_entry),
    .head_valid  (head_valid),
    .pop         (pop),
    .head        (head)
  );

  // back: fold and result register
  nrcc_back #(
    .CRC_SHIFT_STEPS (CRC_SHIFT_STEPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (out_value),
    .out_bytes  (out_bytes),
    .out_match  (out_match)
  );

  assign m_axis_tdata = {5'b0, out_match, out_bytes, out_value};

endmodule
